// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SKBP_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
	else $error("skbp assertion failed");

// next-cycle implication, disabled during reset
`define SKBP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
	else $error("skbp assertion failed");

`endif

// ===== src/skbp_pkg.sv =====
`timescale 1ns / 1ps

package skbp_pkg;

	localparam int RES_W      = 34;
	localparam int TOT_W      = 37;
	localparam int SEQ_W      = 32;
	localparam int FRAME_W    = 32;
	localparam int TAG_W      = 8;
	localparam int OC_W       = 4;
	localparam int CMD_W      = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int REUSE_W    = 9;
	localparam int ALLOC_W    = 11;
	localparam int IDLE_W     = 16;

	localparam logic [REUSE_W-1:0] REUSE_RST = 9'd256;
	localparam logic [ALLOC_W-1:0] ALLOC_RST = 11'd256;
	localparam logic [IDLE_W-1:0]  IDLE_RST  = 16'd0;

	typedef enum logic [CMD_W-1:0] {
		CMD_REQUEST = 2'd0,
		CMD_RETURN  = 2'd1,
		CMD_PROVIDE = 2'd2,
		CMD_COLLECT = 2'd3
	} cmd_t;

	typedef enum logic [OC_W-1:0] {
		OC_EMPTY_GRANT = 4'd0,
		OC_POOL_GRANT  = 4'd1,
		OC_QUEUED      = 4'd2,
		OC_QUEUE_FULL  = 4'd3,
		OC_TO_WAITER   = 4'd4,
		OC_PARKED      = 4'd5,
		OC_POOL_FULL   = 4'd6,
		OC_ALLOCATE    = 4'd7,
		OC_EVICTED     = 4'd8,
		OC_DONE        = 4'd9
	} outcome_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_REUSE = 2'd0,
		CFG_ALLOC = 2'd1,
		CFG_IDLE  = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic load;
		logic clear;
		logic step;
		logic eval;
		logic decide;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic imm;
		logic scan_last;
		logic more;
		logic out_free;
	} dp_sts_t;

endpackage

// ===== src/skbp_ifs.sv =====
`timescale 1ns / 1ps

interface skbp_req_if #(
	parameter int SIZE_BITS   = 32,
	parameter int HANDLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic [skbp_pkg::CMD_W-1:0]    command;
	logic [SIZE_BITS-1:0]          item_size;
	logic [skbp_pkg::TAG_W-1:0]    request_tag;
	logic [HANDLE_BITS-1:0]        buffer_id;
	logic [skbp_pkg::FRAME_W-1:0]  current_frame;

	modport source (output valid, command, item_size, request_tag, buffer_id, current_frame,
		input ready);
	modport sink (input valid, command, item_size, request_tag, buffer_id, current_frame,
		output ready);
endinterface

interface skbp_rsp_if #(
	parameter int HANDLE_BITS = 16
);
	logic                        valid;
	logic                        ready;
	logic [skbp_pkg::OC_W-1:0]   outcome;
	logic [skbp_pkg::TAG_W-1:0]  served_tag;
	logic [HANDLE_BITS-1:0]      served_buffer;
	logic [skbp_pkg::RES_W-1:0]  result_size;
	logic [skbp_pkg::TOT_W-1:0]  pool_bytes;
	logic                        last;

	modport source (output valid, outcome, served_tag, served_buffer, result_size, pool_bytes,
		last, input ready);
	modport sink (input valid, outcome, served_tag, served_buffer, result_size, pool_bytes,
		last, output ready);
endinterface

// ===== src/skbp_ctrl.sv =====
`timescale 1ns / 1ps

module skbp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  skbp_pkg::dp_sts_t   sts,
	output skbp_pkg::dp_cmd_t   cmd
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_SCAN   = 6'b000010,
		S_TAIL   = 6'b000100,
		S_EVAL   = 6'b001000,
		S_DECIDE = 6'b010000,
		S_EMIT   = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = sts.imm ? S_EMIT : S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.step = 1'b1;
				if (sts.scan_last) state_d = S_TAIL;
			end
			S_TAIL: state_d = S_EVAL;
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = S_DECIDE;
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.more) begin
						cmd.clear = 1'b1;
						state_d   = S_SCAN;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign req_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== src/skbp_dp.sv =====
`timescale 1ns / 1ps

module skbp_dp #(
	parameter int POOL_ENTRIES = 32,
	parameter int WAIT_ENTRIES = 16,
	parameter int SIZE_BITS    = 32,
	parameter int HANDLE_BITS  = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [skbp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [skbp_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic [skbp_pkg::CMD_W-1:0]         command,
	input  logic [SIZE_BITS-1:0]               item_size,
	input  logic [skbp_pkg::TAG_W-1:0]         request_tag,
	input  logic [HANDLE_BITS-1:0]             buffer_id,
	input  logic [skbp_pkg::FRAME_W-1:0]       current_frame,
	input  logic                               rsp_ready,
	output logic                               rsp_valid,
	output logic [skbp_pkg::OC_W-1:0]          outcome,
	output logic [skbp_pkg::TAG_W-1:0]         served_tag,
	output logic [HANDLE_BITS-1:0]             served_buffer,
	output logic [skbp_pkg::RES_W-1:0]         result_size,
	output logic [skbp_pkg::TOT_W-1:0]         pool_bytes,
	output logic                               last,
	input  skbp_pkg::dp_cmd_t                  cmd,
	output skbp_pkg::dp_sts_t                  sts
);

	localparam int SCAN_N = (POOL_ENTRIES > WAIT_ENTRIES) ? POOL_ENTRIES : WAIT_ENTRIES;
	localparam int IW     = $clog2(SCAN_N);
	localparam int PIW    = $clog2(POOL_ENTRIES);
	localparam int WIW    = (WAIT_ENTRIES > 1) ? $clog2(WAIT_ENTRIES) : 1;
	localparam int PW     = SIZE_BITS + skbp_pkg::ALLOC_W;
	localparam int AW     = PW - 8;
	localparam logic [skbp_pkg::RES_W-1:0] RES_MAX = '1;

	typedef struct packed {
		logic [SIZE_BITS-1:0]              size;
		logic [skbp_pkg::FRAME_W-1:0]      frame;
		logic [HANDLE_BITS-1:0]            handle;
		logic [skbp_pkg::SEQ_W-1:0]        seq;
	} pent_t;

	typedef struct packed {
		logic [SIZE_BITS-1:0]              size;
		logic [skbp_pkg::TAG_W-1:0]        tag;
		logic [skbp_pkg::SEQ_W-1:0]        seq;
	} went_t;

	// configuration
	logic [skbp_pkg::REUSE_W-1:0] reuse_q;
	logic [skbp_pkg::ALLOC_W-1:0] alloc_q;
	logic [skbp_pkg::IDLE_W-1:0]  idle_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reuse_q <= skbp_pkg::REUSE_RST;
			alloc_q <= skbp_pkg::ALLOC_RST;
			idle_q  <= skbp_pkg::IDLE_RST;
		end else if (cfg_we) begin
			case (skbp_pkg::cfg_idx_t'(cfg_index))
				skbp_pkg::CFG_REUSE: reuse_q <= cfg_data[skbp_pkg::REUSE_W-1:0];
				skbp_pkg::CFG_ALLOC: alloc_q <= cfg_data[skbp_pkg::ALLOC_W-1:0];
				skbp_pkg::CFG_IDLE:  idle_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// latched transaction
	skbp_pkg::cmd_t               cmd_q;
	logic [SIZE_BITS-1:0]         size_q;
	logic [skbp_pkg::TAG_W-1:0]   tag_q;
	logic [HANDLE_BITS-1:0]       buf_q;
	logic [skbp_pkg::FRAME_W-1:0] frame_q;
	logic [skbp_pkg::FRAME_W-1:0] limit_q;
	skbp_pkg::cmd_t               in_cmd;

	assign in_cmd = skbp_pkg::cmd_t'(command);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q   <= in_cmd;
			size_q  <= item_size;
			tag_q   <= request_tag;
			buf_q   <= buffer_id;
			frame_q <= current_frame;
			limit_q <= (current_frame >= skbp_pkg::FRAME_W'(idle_q))
				? current_frame - skbp_pkg::FRAME_W'(idle_q) : '0;
		end
	end

	assign sts.imm = (in_cmd == skbp_pkg::CMD_REQUEST && item_size == '0) ||
		(in_cmd == skbp_pkg::CMD_RETURN && buffer_id == '0) ||
		(in_cmd == skbp_pkg::CMD_COLLECT && idle_q == '0);

	// scan counter and first stage
	logic [IW-1:0] cnt_q;
	logic [IW-1:0] idx_s1;
	logic          act_s1, pv_s1, pfree_s1, wv_s1, wfree_s1;
	logic [POOL_ENTRIES-1:0] pool_vld_q;
	logic [WAIT_ENTRIES-1:0] wait_vld_q;
	logic          cnt_in_pool, cnt_in_wait;

	assign sts.scan_last = (cnt_q == IW'(SCAN_N - 1));
	assign cnt_in_pool   = (32'(cnt_q) < POOL_ENTRIES);
	assign cnt_in_wait   = (32'(cnt_q) < WAIT_ENTRIES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			act_s1 <= 1'b0;
		end else begin
			act_s1 <= cmd.step;
			if (cmd.load || cmd.clear) cnt_q <= '0;
			else if (cmd.step) cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1   <= cnt_q;
		pv_s1    <= cnt_in_pool && pool_vld_q[cnt_q[PIW-1:0]];
		pfree_s1 <= cnt_in_pool && !pool_vld_q[cnt_q[PIW-1:0]];
		wv_s1    <= cnt_in_wait && wait_vld_q[cnt_q[WIW-1:0]];
		wfree_s1 <= cnt_in_wait && !wait_vld_q[cnt_q[WIW-1:0]];
	end

	// memories
	pent_t pool_mem [POOL_ENTRIES];
	went_t wait_mem [WAIT_ENTRIES];
	pent_t pr_q;
	went_t wr_q;
	logic  p_set, p_clr, w_set, w_clr;
	logic [IW-1:0] w_clr_idx;
	logic [skbp_pkg::SEQ_W-1:0] seq_q;

	// best-candidate registers
	logic                          b_found_q, l_found_q, f_found_q;
	logic [IW-1:0]                 b_idx_q, l_idx_q, f_idx_q;
	logic [SIZE_BITS-1:0]          b_size_q, l_size_q;
	logic [skbp_pkg::SEQ_W-1:0]    b_seq_q, l_seq_q;
	logic [HANDLE_BITS-1:0]        b_handle_q;
	logic [skbp_pkg::TAG_W-1:0]    b_tag_q, l_tag_q;

	always_ff @(posedge clk) begin
		if (p_set) pool_mem[f_idx_q[PIW-1:0]] <= '{size: size_q, frame: frame_q,
			handle: buf_q, seq: seq_q};
		pr_q <= pool_mem[cnt_q[PIW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (w_set) wait_mem[f_idx_q[WIW-1:0]] <= '{size: size_q, tag: tag_q, seq: seq_q};
		wr_q <= wait_mem[cnt_q[WIW-1:0]];
	end

	function automatic logic ahead(input logic [SIZE_BITS-1:0] sa,
		input logic [skbp_pkg::SEQ_W-1:0] qa, input logic [SIZE_BITS-1:0] sb,
		input logic [skbp_pkg::SEQ_W-1:0] qb);
		return (sa < sb) || (sa == sb && qa < qb);
	endfunction

	logic cand_req, cand_col, cand_eq, cand_lt, cand_prov;

	assign cand_req  = pv_s1 && pr_q.size >= size_q &&
		(!b_found_q || ahead(pr_q.size, pr_q.seq, b_size_q, b_seq_q));
	assign cand_col  = pv_s1 && pr_q.frame < limit_q &&
		(!b_found_q || ahead(pr_q.size, pr_q.seq, b_size_q, b_seq_q));
	assign cand_eq   = wv_s1 && wr_q.size == size_q && (!b_found_q || wr_q.seq < b_seq_q);
	// largest smaller size, latest among equals
	assign cand_lt   = wv_s1 && wr_q.size < size_q &&
		(!l_found_q || ahead(l_size_q, l_seq_q, wr_q.size, wr_q.seq));
	assign cand_prov = wv_s1 && (!b_found_q || ahead(wr_q.size, wr_q.seq, b_size_q, b_seq_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_found_q <= 1'b0;
			l_found_q <= 1'b0;
			f_found_q <= 1'b0;
		end else if (cmd.load || cmd.clear) begin
			b_found_q <= 1'b0;
			l_found_q <= 1'b0;
			f_found_q <= 1'b0;
		end else if (act_s1) begin
			unique case (cmd_q)
				skbp_pkg::CMD_REQUEST: begin
					if (cand_req) b_found_q <= 1'b1;
					if (wfree_s1) f_found_q <= 1'b1;
				end
				skbp_pkg::CMD_COLLECT: begin
					if (cand_col) b_found_q <= 1'b1;
				end
				skbp_pkg::CMD_RETURN: begin
					if (cand_eq) b_found_q <= 1'b1;
					if (cand_lt) l_found_q <= 1'b1;
					if (pfree_s1) f_found_q <= 1'b1;
				end
				skbp_pkg::CMD_PROVIDE: begin
					if (cand_prov) b_found_q <= 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (act_s1) begin
			unique case (cmd_q)
				skbp_pkg::CMD_REQUEST, skbp_pkg::CMD_COLLECT: begin
					if ((cmd_q == skbp_pkg::CMD_REQUEST) ? cand_req : cand_col) begin
						b_idx_q    <= idx_s1;
						b_size_q   <= pr_q.size;
						b_seq_q    <= pr_q.seq;
						b_handle_q <= pr_q.handle;
					end
					if (cmd_q == skbp_pkg::CMD_REQUEST && wfree_s1 && !f_found_q)
						f_idx_q <= idx_s1;
				end
				skbp_pkg::CMD_RETURN, skbp_pkg::CMD_PROVIDE: begin
					if ((cmd_q == skbp_pkg::CMD_RETURN) ? cand_eq : cand_prov) begin
						b_idx_q  <= idx_s1;
						b_size_q <= wr_q.size;
						b_seq_q  <= wr_q.seq;
						b_tag_q  <= wr_q.tag;
					end
					if (cmd_q == skbp_pkg::CMD_RETURN && cand_lt) begin
						l_idx_q  <= idx_s1;
						l_size_q <= wr_q.size;
						l_seq_q  <= wr_q.seq;
						l_tag_q  <= wr_q.tag;
					end
					if (cmd_q == skbp_pkg::CMD_RETURN && pfree_s1 && !f_found_q)
						f_idx_q <= idx_s1;
				end
			endcase
		end
	end

	// ratio product: reuse test for requests, allocation size for provide
	logic [PW-1:0] prod_q;
	logic [skbp_pkg::ALLOC_W-1:0] ratio;

	assign ratio = (cmd_q == skbp_pkg::CMD_REQUEST) ? skbp_pkg::ALLOC_W'(reuse_q) : alloc_q;

	always_ff @(posedge clk) begin
		if (cmd.eval) prod_q <= PW'(b_size_q) * PW'(ratio);
	end

	logic          req_ok;
	logic [AW-1:0] alloc_v;
	logic [63:0]   alloc64;
	logic [skbp_pkg::RES_W-1:0] alloc_sat;

	assign req_ok    = b_found_q && (PW'({size_q, 8'h00}) >= prod_q);
	assign alloc_v   = prod_q[PW-1:8];
	assign alloc64   = 64'(alloc_v);
	assign alloc_sat = (alloc64 > 64'(RES_MAX)) ? RES_MAX : alloc64[skbp_pkg::RES_W-1:0];

	skbp_pkg::outcome_t          d_oc;
	logic [skbp_pkg::TAG_W-1:0]  d_tag;
	logic [HANDLE_BITS-1:0]      d_buf;
	logic [skbp_pkg::RES_W-1:0]  d_size;
	logic                        d_last, tot_add, tot_sub, seq_inc;

	always_comb begin
		d_oc      = skbp_pkg::OC_DONE;
		d_tag     = '0;
		d_buf     = '0;
		d_size    = '0;
		d_last    = 1'b1;
		p_set     = 1'b0;
		p_clr     = 1'b0;
		w_set     = 1'b0;
		w_clr     = 1'b0;
		w_clr_idx = b_idx_q;
		tot_add   = 1'b0;
		tot_sub   = 1'b0;
		seq_inc   = 1'b0;
		if (cmd.decide) begin
			unique case (cmd_q)
				skbp_pkg::CMD_REQUEST: begin
					d_tag = tag_q;
					if (req_ok) begin
						p_clr   = 1'b1;
						tot_sub = 1'b1;
						d_oc    = skbp_pkg::OC_POOL_GRANT;
						d_buf   = b_handle_q;
						d_size  = skbp_pkg::RES_W'(b_size_q);
					end else if (f_found_q) begin
						w_set   = 1'b1;
						seq_inc = 1'b1;
						d_oc    = skbp_pkg::OC_QUEUED;
					end else begin
						d_oc = skbp_pkg::OC_QUEUE_FULL;
					end
				end
				skbp_pkg::CMD_RETURN: begin
					d_buf  = buf_q;
					d_size = skbp_pkg::RES_W'(size_q);
					if (b_found_q || l_found_q) begin
						w_clr     = 1'b1;
						w_clr_idx = b_found_q ? b_idx_q : l_idx_q;
						d_tag     = b_found_q ? b_tag_q : l_tag_q;
						d_oc      = skbp_pkg::OC_TO_WAITER;
					end else if (f_found_q) begin
						p_set   = 1'b1;
						tot_add = 1'b1;
						seq_inc = 1'b1;
						d_oc    = skbp_pkg::OC_PARKED;
					end else begin
						d_oc = skbp_pkg::OC_POOL_FULL;
					end
				end
				skbp_pkg::CMD_PROVIDE: begin
					if (b_found_q) begin
						w_clr  = 1'b1;
						d_oc   = skbp_pkg::OC_ALLOCATE;
						d_tag  = b_tag_q;
						d_size = alloc_sat;
						d_last = 1'b0;
					end
				end
				skbp_pkg::CMD_COLLECT: begin
					if (b_found_q) begin
						p_clr   = 1'b1;
						tot_sub = 1'b1;
						d_oc    = skbp_pkg::OC_EVICTED;
						d_buf   = b_handle_q;
						d_size  = skbp_pkg::RES_W'(b_size_q);
						d_last  = 1'b0;
					end
				end
			endcase
		end
	end

	logic [skbp_pkg::TOT_W-1:0] tot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_vld_q <= '0;
			wait_vld_q <= '0;
			tot_q      <= '0;
			seq_q      <= '0;
		end else begin
			if (p_clr) pool_vld_q[b_idx_q[PIW-1:0]] <= 1'b0;
			if (p_set) pool_vld_q[f_idx_q[PIW-1:0]] <= 1'b1;
			if (w_clr) wait_vld_q[w_clr_idx[WIW-1:0]] <= 1'b0;
			if (w_set) wait_vld_q[f_idx_q[WIW-1:0]] <= 1'b1;
			if (tot_add) tot_q <= tot_q + skbp_pkg::TOT_W'(size_q);
			else if (tot_sub) tot_q <= tot_q - skbp_pkg::TOT_W'(b_size_q);
			if (seq_inc) seq_q <= seq_q + 1'b1;
		end
	end

	// pending result, then output register
	skbp_pkg::outcome_t          pend_oc;
	logic [skbp_pkg::TAG_W-1:0]  pend_tag;
	logic [HANDLE_BITS-1:0]      pend_buf;
	logic [skbp_pkg::RES_W-1:0]  pend_size;
	logic                        pend_last_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pend_oc   <= (in_cmd == skbp_pkg::CMD_REQUEST) ? skbp_pkg::OC_EMPTY_GRANT
				: skbp_pkg::OC_DONE;
			pend_tag  <= (in_cmd == skbp_pkg::CMD_REQUEST) ? request_tag : '0;
			pend_buf  <= '0;
			pend_size <= '0;
		end else if (cmd.decide) begin
			pend_oc   <= d_oc;
			pend_tag  <= d_tag;
			pend_buf  <= d_buf;
			pend_size <= d_size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_last_q <= 1'b1;
		end else if (cmd.load) begin
			pend_last_q <= 1'b1;
		end else if (cmd.decide) begin
			pend_last_q <= d_last;
		end
	end

	assign sts.more     = !pend_last_q;
	assign sts.out_free = !rsp_valid || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (cmd.emit) begin
			rsp_valid <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			outcome       <= pend_oc;
			served_tag    <= pend_tag;
			served_buffer <= pend_buf;
			result_size   <= pend_size;
			pool_bytes    <= tot_q;
			last          <= pend_last_q;
		end
	end

endmodule

// ===== src/size_keyed_buffer_pool_core.sv =====
`timescale 1ns / 1ps
// Each scan pass reads one pool and one waiter entry per cycle and compares each against
// the best candidates so far over max(POOL_ENTRIES, WAIT_ENTRIES) entries, then steps
// through tail, eval, decide and emit. Request and return scan once; provide and collect
// rescan without a new accept for each allocation or eviction, closing with a done result.
// Zero-size request, return without buffer and disabled collect skip the scan.
// Reset clears all valid bits, the byte total and order counter, and loads config defaults.

module size_keyed_buffer_pool_core #(
	parameter int POOL_ENTRIES = 32,
	parameter int WAIT_ENTRIES = 16,
	parameter int SIZE_BITS    = 32,
	parameter int HANDLE_BITS  = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [skbp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [skbp_pkg::CFG_DATA_W-1:0]  cfg_data,
	skbp_req_if.sink                         req_ch,
	skbp_rsp_if.source                       rsp_ch
);

	skbp_pkg::dp_cmd_t dp_cmd;
	skbp_pkg::dp_sts_t dp_sts;

	skbp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_ch.valid),
		.req_ready (req_ch.ready),
		.sts       (dp_sts),
		.cmd       (dp_cmd)
	);

	skbp_dp #(
		.POOL_ENTRIES (POOL_ENTRIES),
		.WAIT_ENTRIES (WAIT_ENTRIES),
		.SIZE_BITS    (SIZE_BITS),
		.HANDLE_BITS  (HANDLE_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.command       (req_ch.command),
		.item_size     (req_ch.item_size),
		.request_tag   (req_ch.request_tag),
		.buffer_id     (req_ch.buffer_id),
		.current_frame (req_ch.current_frame),
		.rsp_ready     (rsp_ch.ready),
		.rsp_valid     (rsp_ch.valid),
		.outcome       (rsp_ch.outcome),
		.served_tag    (rsp_ch.served_tag),
		.served_buffer (rsp_ch.served_buffer),
		.result_size   (rsp_ch.result_size),
		.pool_bytes    (rsp_ch.pool_bytes),
		.last          (rsp_ch.last),
		.cmd           (dp_cmd),
		.sts           (dp_sts)
	);

endmodule

// ===== src/skbp_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module skbp_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       req_valid,
	input logic                       req_ready,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic [skbp_pkg::OC_W-1:0]  outcome,
	input logic                       last
);

	logic rsp_stall;
	logic req_take;
	logic single_oc;
	logic multi_oc;

	assign rsp_stall = rsp_valid && !rsp_ready;
	assign req_take  = req_valid && req_ready;
	assign single_oc = outcome == skbp_pkg::OC_EMPTY_GRANT ||
		outcome == skbp_pkg::OC_POOL_GRANT ||
		outcome == skbp_pkg::OC_QUEUED || outcome == skbp_pkg::OC_QUEUE_FULL ||
		outcome == skbp_pkg::OC_TO_WAITER || outcome == skbp_pkg::OC_PARKED ||
		outcome == skbp_pkg::OC_POOL_FULL || outcome == skbp_pkg::OC_DONE;
	assign multi_oc = outcome == skbp_pkg::OC_ALLOCATE || outcome == skbp_pkg::OC_EVICTED;

	// a stalled response keeps its contents
	`SKBP_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_stall, rsp_valid && $stable(outcome) && $stable(last))
	// every visible outcome is a defined code
	`SKBP_ASSERT_IMPLY(a_oc_legal, clk, arst_n, rsp_valid, single_oc || multi_oc)
	// allocations and evictions are never marked last
	`SKBP_ASSERT_IMPLY(a_multi_not_last, clk, arst_n, rsp_valid && multi_oc, !last)
	// a new transaction is never taken while the previous one is mid-flight
	`SKBP_ASSERT_IMPLY(a_ready_after_last, clk, arst_n, rsp_valid && !last, !req_ready)
	// one transaction at a time
	`SKBP_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, req_take, !req_ready)

endmodule

bind size_keyed_buffer_pool_core skbp_checker u_skbp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_ch.valid),
	.req_ready (req_ch.ready),
	.rsp_valid (rsp_ch.valid),
	.rsp_ready (rsp_ch.ready),
	.outcome   (rsp_ch.outcome),
	.last      (rsp_ch.last)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

	typedef struct {
		skbp_pkg::cmd_t cmd;
		bit [31:0]      size;
		bit [7:0]       tag;
		bit [15:0]      hnd;
		bit [31:0]      frame;
	} pool_cmd_t;

	typedef struct {
		skbp_pkg::outcome_t oc;
		bit [7:0]           tag;
		bit [15:0]          hnd;
		bit [33:0]          sz;
		bit [36:0]          bytes;
		bit                 last;
	} pool_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [skbp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [skbp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	skbp_req_if #(.SIZE_BITS(32), .HANDLE_BITS(16)) req_ch();
	skbp_rsp_if #(.HANDLE_BITS(16)) rsp_ch();

	size_keyed_buffer_pool_core uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .req_ch(req_ch), .rsp_ch(rsp_ch)
	);

	always #5 clk = ~clk;

	pool_cmd_t pending_cmds[$];
	pool_result_t expected_results[$];
	int errors = 0;
	bit [31:0] frame_now = 0;

	// shadow state
	bit [8:0]  m_reuse = 9'd256;
	bit [10:0] m_alloc = 11'd256;
	bit [15:0] m_idle = 16'd0;
	bit        m_pv[32];
	bit [31:0] m_psize[32];
	bit [31:0] m_pframe[32];
	bit [15:0] m_phnd[32];
	longint unsigned m_pseq[32];
	bit        m_wv[16];
	bit [31:0] m_wsize[16];
	bit [7:0]  m_wtag[16];
	longint unsigned m_wseq[16];
	bit [36:0] m_total = '0;
	longint unsigned m_seq = 0;

	function automatic bit precedes(bit [31:0] sa, longint unsigned qa, bit [31:0] sb,
			longint unsigned qb);
		return sa < sb || (sa == sb && qa < qb);
	endfunction

	function automatic void emit(skbp_pkg::outcome_t oc, bit [7:0] tag, bit [15:0] hnd,
			bit [33:0] sz);
		pool_result_t r;
		r.oc = oc; r.tag = tag; r.hnd = hnd; r.sz = sz; r.bytes = m_total; r.last = 1'b0;
		expected_results.push_back(r);
	endfunction

	function automatic void predict_pool(pool_cmd_t c);
		int best;
		int i;
		bit [63:0] a;
		bit [31:0] lim;
		pool_result_t r;
		best = -1;
		case (c.cmd)
			skbp_pkg::CMD_REQUEST: begin
				if (c.size == 0) begin
					emit(skbp_pkg::OC_EMPTY_GRANT, c.tag, 16'd0, 34'd0);
				end else begin
					for (i = 0; i < 32; i++)
						if (m_pv[i] && m_psize[i] >= c.size && (best < 0 ||
								precedes(m_psize[i], m_pseq[i], m_psize[best], m_pseq[best])))
							best = i;
					if (best >= 0 && 64'(c.size) * 256 >= 64'(m_psize[best]) * 64'(m_reuse))
							begin
						m_pv[best] = 0;
						m_total = m_total - 37'(m_psize[best]);
						emit(skbp_pkg::OC_POOL_GRANT, c.tag, m_phnd[best], 34'(m_psize[best]));
					end else begin
						for (i = 0; i < 16 && m_wv[i]; i++) ;
						if (i < 16) begin
							m_wv[i] = 1; m_wsize[i] = c.size; m_wtag[i] = c.tag;
							m_wseq[i] = m_seq++;
							emit(skbp_pkg::OC_QUEUED, c.tag, 16'd0, 34'd0);
						end else begin
							emit(skbp_pkg::OC_QUEUE_FULL, c.tag, 16'd0, 34'd0);
						end
					end
				end
			end
			skbp_pkg::CMD_RETURN: begin
				if (c.hnd == 0) begin
					emit(skbp_pkg::OC_DONE, 8'd0, 16'd0, 34'd0);
				end else begin
					for (i = 0; i < 16; i++)
						if (m_wv[i] && m_wsize[i] == c.size &&
								(best < 0 || m_wseq[i] < m_wseq[best]))
							best = i;
					if (best < 0)
						for (i = 0; i < 16; i++)
							if (m_wv[i] && m_wsize[i] < c.size && (best < 0 ||
									precedes(m_wsize[best], m_wseq[best], m_wsize[i], m_wseq[i])))
								best = i;
					if (best >= 0) begin
						m_wv[best] = 0;
						emit(skbp_pkg::OC_TO_WAITER, m_wtag[best], c.hnd, 34'(c.size));
					end else begin
						for (i = 0; i < 32 && m_pv[i]; i++) ;
						if (i < 32) begin
							m_pv[i] = 1; m_psize[i] = c.size; m_pframe[i] = c.frame;
							m_phnd[i] = c.hnd; m_pseq[i] = m_seq++;
							m_total = m_total + 37'(c.size);
							emit(skbp_pkg::OC_PARKED, 8'd0, c.hnd, 34'(c.size));
						end else begin
							emit(skbp_pkg::OC_POOL_FULL, 8'd0, c.hnd, 34'(c.size));
						end
					end
				end
			end
			skbp_pkg::CMD_PROVIDE: begin
				forever begin
					best = -1;
					for (i = 0; i < 16; i++)
						if (m_wv[i] && (best < 0 ||
								precedes(m_wsize[i], m_wseq[i], m_wsize[best], m_wseq[best])))
							best = i;
					if (best < 0) break;
					m_wv[best] = 0;
					a = (64'(m_wsize[best]) * 64'(m_alloc)) >> 8;
					if (a > 64'h3_FFFF_FFFF) a = 64'h3_FFFF_FFFF;
					emit(skbp_pkg::OC_ALLOCATE, m_wtag[best], 16'd0, a[33:0]);
				end
				emit(skbp_pkg::OC_DONE, 8'd0, 16'd0, 34'd0);
			end
			default: begin
				if (m_idle != 0) begin
					lim = (c.frame >= 32'(m_idle)) ? c.frame - 32'(m_idle) : 32'd0;
					forever begin
						best = -1;
						for (i = 0; i < 32; i++)
							if (m_pv[i] && m_pframe[i] < lim && (best < 0 ||
									precedes(m_psize[i], m_pseq[i], m_psize[best], m_pseq[best])))
								best = i;
						if (best < 0) break;
						m_pv[best] = 0;
						m_total = m_total - 37'(m_psize[best]);
						emit(skbp_pkg::OC_EVICTED, 8'd0, m_phnd[best], 34'(m_psize[best]));
					end
				end
				emit(skbp_pkg::OC_DONE, 8'd0, 16'd0, 34'd0);
			end
		endcase
		r = expected_results.pop_back();
		r.last = 1'b1;
		expected_results.push_back(r);
	endfunction

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 65) return 0;
		if (p < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// driver
	int send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				predict_pool('{skbp_pkg::cmd_t'(req_ch.command), req_ch.item_size,
					req_ch.request_tag, req_ch.buffer_id, req_ch.current_frame});
			if (!req_ch.valid || req_ch.ready) begin
				if (send_gap == 0 && pending_cmds.size() != 0) begin
					pool_cmd_t c;
					c = pending_cmds.pop_front();
					req_ch.command <= c.cmd;
					req_ch.item_size <= c.size;
					req_ch.request_tag <= c.tag;
					req_ch.buffer_id <= c.hnd;
					req_ch.current_frame <= c.frame;
					req_ch.valid <= 1'b1;
					send_gap = pick_gap();
				end else begin
					req_ch.valid <= 1'b0;
					if (send_gap > 0) send_gap--;
				end
			end
		end
	end

	// monitor
	int stall = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_results.size() == 0) begin
					$error("result with no expectation: outcome %0d", rsp_ch.outcome);
					errors++;
				end else begin
					pool_result_t e;
					e = expected_results.pop_front();
					if (rsp_ch.outcome !== e.oc) begin
						$error("outcome: expected %0d actual %0d", e.oc, rsp_ch.outcome); errors++;
					end
					if (rsp_ch.served_tag !== e.tag) begin
						$error("served_tag: expected %0d actual %0d", e.tag, rsp_ch.served_tag);
						errors++;
					end
					if (rsp_ch.served_buffer !== e.hnd) begin
						$error("served_buffer: expected %0d actual %0d", e.hnd,
							rsp_ch.served_buffer);
						errors++;
					end
					if (rsp_ch.result_size !== e.sz) begin
						$error("result_size: expected %0d actual %0d", e.sz, rsp_ch.result_size);
						errors++;
					end
					if (rsp_ch.pool_bytes !== e.bytes) begin
						$error("pool_bytes: expected %0d actual %0d", e.bytes, rsp_ch.pool_bytes);
						errors++;
					end
					if (rsp_ch.last !== e.last) begin
						$error("last: expected %0d actual %0d", e.last, rsp_ch.last); errors++;
					end
				end
			end
			if (stall > 0) begin
				stall--;
				rsp_ch.ready <= 1'b0;
			end else begin
				stall = pick_gap();
				rsp_ch.ready <= (stall == 0);
			end
		end
	end

	initial begin
		req_ch.valid = 1'b0;
		req_ch.command = skbp_pkg::CMD_REQUEST;
		req_ch.item_size = '0;
		req_ch.request_tag = '0;
		req_ch.buffer_id = '0;
		req_ch.current_frame = '0;
		rsp_ch.ready = 1'b0;
	end

	task automatic add(skbp_pkg::cmd_t cmd, bit [31:0] size, bit [7:0] tag, bit [15:0] hnd,
			bit [31:0] frame);
		pending_cmds.push_back('{cmd, size, tag, hnd, frame});
	endtask

	function automatic bit [31:0] rand_size();
		int p;
		p = $urandom_range(0, 99);
		if (p < 8) return 0;
		if (p < 18) return $urandom;
		if (p < 22) return 32'hFFFF_FFFF;
		return 32'($urandom_range(1, 16) * 32);
	endfunction

	task automatic add_random(int n);
		int p;
		bit [15:0] h;
		repeat (n) begin
			p = $urandom_range(0, 99);
			frame_now += $urandom_range(0, 3);
			h = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
			if (p < 40)
				add(skbp_pkg::CMD_REQUEST, rand_size(), 8'($urandom), 16'($urandom), frame_now);
			else if (p < 80)
				add(skbp_pkg::CMD_RETURN, rand_size(), 8'($urandom), h, frame_now);
			else if (p < 88)
				add(skbp_pkg::CMD_PROVIDE, $urandom, 8'($urandom), 16'($urandom), frame_now);
			else add(skbp_pkg::CMD_COLLECT, $urandom, 8'($urandom), 16'($urandom),
				($urandom_range(0, 9) == 0) ? $urandom : frame_now);
		end
	endtask

	task automatic drain();
		do @(posedge clk);
		while (pending_cmds.size() != 0 || req_ch.valid || expected_results.size() != 0);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(skbp_pkg::cfg_idx_t idx, bit [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			skbp_pkg::CFG_REUSE: m_reuse = val[8:0];
			skbp_pkg::CFG_ALLOC: m_alloc = val[10:0];
			default:             m_idle = val;
		endcase
	endtask

	task automatic configure(bit [15:0] reuse, bit [15:0] alloc, bit [15:0] idle);
		write_reg(skbp_pkg::CFG_REUSE, reuse);
		write_reg(skbp_pkg::CFG_ALLOC, alloc);
		write_reg(skbp_pkg::CFG_IDLE, idle);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int i;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults from reset
		add(skbp_pkg::CMD_REQUEST, 0, 8'd1, 0, 0);
		add(skbp_pkg::CMD_REQUEST, 32'hFFFF_FFFF, 8'd2, 0, 0);
		add(skbp_pkg::CMD_REQUEST, 100, 8'd3, 0, 0);
		add(skbp_pkg::CMD_REQUEST, 100, 8'd4, 0, 0);
		add(skbp_pkg::CMD_REQUEST, 50, 8'd5, 0, 0);
		add(skbp_pkg::CMD_RETURN, 100, 0, 16'd10, 1);            // equal size, earliest
		add(skbp_pkg::CMD_RETURN, 80, 0, 16'd11, 1);             // largest smaller size
		add(skbp_pkg::CMD_RETURN, 70, 0, 16'd0, 1);              // no buffer
		add(skbp_pkg::CMD_RETURN, 32'hFFFF_FFFF, 0, 16'hFFFF, 2);
		add(skbp_pkg::CMD_RETURN, 300, 0, 16'd12, 2);
		add(skbp_pkg::CMD_RETURN, 300, 0, 16'd13, 3);
		add(skbp_pkg::CMD_REQUEST, 300, 8'd6, 0, 3);
		add(skbp_pkg::CMD_RETURN, 400, 0, 16'd14, 3);
		add(skbp_pkg::CMD_REQUEST, 300, 8'd7, 0, 4);              // ratio test fails
		add(skbp_pkg::CMD_PROVIDE, 0, 0, 0, 4);
		add(skbp_pkg::CMD_COLLECT, 0, 0, 0, 32'hFFFF_FFFF);       // collection disabled
		drain();

		configure(16'd0, 16'd1024, 16'd5);
		add(skbp_pkg::CMD_RETURN, 500, 0, 16'd20, 2);
		add(skbp_pkg::CMD_COLLECT, 0, 0, 0, 3);                  // limit clamps to zero
		add(skbp_pkg::CMD_REQUEST, 1, 8'hFF, 0, 4);              // any larger size reused
		add(skbp_pkg::CMD_REQUEST, 32'hFFFF_FFFF, 8'hAA, 0, 5);
		add(skbp_pkg::CMD_PROVIDE, 0, 0, 0, 5);
		add(skbp_pkg::CMD_RETURN, 64, 0, 16'd21, 6);
		add(skbp_pkg::CMD_COLLECT, 0, 0, 0, 100);
		frame_now = 100;
		// fill the waiter queue past its depth, then the pool past its depth
		for (i = 0; i < 18; i++)
			add(skbp_pkg::CMD_REQUEST, 32'($urandom_range(1, 8) * 32), 8'($urandom), 0, 100);
		add(skbp_pkg::CMD_PROVIDE, 0, 0, 0, 100);
		for (i = 0; i < 34; i++) begin
			frame_now += $urandom_range(0, 2);
			add(skbp_pkg::CMD_RETURN, rand_size() | 1, 0, 16'($urandom_range(1, 65535)),
				frame_now);
		end
		add(skbp_pkg::CMD_COLLECT, 0, 0, 0, frame_now + 3);
		add_random(35);
		drain();

		configure(16'd192, 16'd384, 16'd65535);
		frame_now = 32'hFFFF_0000;
		add_random(50);
		drain();

		configure(16'd256, 16'd1024, 16'd1);
		add_random(50);
		drain();

		if (errors == 0 && expected_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			if (expected_results.size() != 0)
				$error("%0d expected results never arrived", expected_results.size());
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#50ms;
		$display("Some tests failed");
		$finish;
	end

endmodule
